### rtl/ipcl_pkg.sv
// Shared constants, codes and types of the IP prefix category lookup block.
`default_nettype none

package ipcl_pkg;

    // Default table sizes and category bound
    localparam int V4_ENTRIES_DEF     = 256;
    localparam int V6_ENTRIES_DEF     = 256;
    localparam int CATEGORY_LIMIT_DEF = 128;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int HALF_W   = 64;
    localparam int KEY_W    = 128;
    localparam int PREFIX_W = 8;
    localparam int CAT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W = 1;

    // Stored entry layouts: {network, prefix, category}
    localparam int V4_NET_W    = 32;
    localparam int V4_PREFIX_W = 6;
    localparam int V4_ENTRY_W  = V4_NET_W + V4_PREFIX_W + CAT_W;
    localparam int V6_ENTRY_W  = KEY_W + PREFIX_W + CAT_W;

    localparam logic [PREFIX_W-1:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [PREFIX_W-1:0] V6_MAX_PREFIX = 8'd128;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WR4 = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR6 = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LK4 = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LK6 = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IPV4_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IPV6_COUNT = 1'd1;

    // Sequencer to match unit
    typedef struct packed {
        logic start;   // clear the running best
        logic eval;    // read data of one entry is present
    } t_scan_ctl;

    // Running best of a scan
    typedef struct packed {
        logic                found;
        logic [PREFIX_W-1:0] len;
        logic [CAT_W-1:0]    cat;
    } t_best;

endpackage

`default_nettype wire

### rtl/ipcl_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
`default_nettype none

module ipcl_ram #(
    parameter int WIDTH = ipcl_pkg::V4_ENTRY_W,
    parameter int DEPTH = ipcl_pkg::V4_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ipcl_match.sv
// Prefix cover test and running longest-match tracker for one table scan.
`default_nettype none

module ipcl_match (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ipcl_pkg::t_scan_ctl                 i_ctl,
    input  wire logic [ipcl_pkg::KEY_W-1:0]          i_key,
    input  wire logic [ipcl_pkg::KEY_W-1:0]          i_net,
    input  wire logic [ipcl_pkg::PREFIX_W-1:0]       i_len,
    input  wire logic [ipcl_pkg::CAT_W-1:0]          i_cat,
    output ipcl_pkg::t_best                          o_best
);

    logic [ipcl_pkg::KEY_W-1:0] mask;
    logic                       covers;
    logic                       better;
    ipcl_pkg::t_best            r_best;
    ipcl_pkg::t_best            n_best;

    // Top len bits set; keys are left aligned, so IPv4 uses the top 32 bits
    assign mask   = ~({ipcl_pkg::KEY_W{1'b1}} >> i_len);
    assign covers = (i_len <= ipcl_pkg::V6_MAX_PREFIX) && (((i_key ^ i_net) & mask) == '0);
    // Strictly longer only: on a tie the lower slot, seen first, stays
    assign better = covers && (!r_best.found || (i_len > r_best.len));

    always_comb begin
        n_best = r_best;
        if (i_ctl.start) begin
            n_best = '0;
        end else if (i_ctl.eval && better) begin
            n_best.found = 1'b1;
            n_best.len   = i_len;
            n_best.cat   = i_cat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

### rtl/ip_prefix_category_lookup.sv
// Top level: longest-prefix category lookup over IPv4 and IPv6 linear tables.
//
//  channel | signals                                         | direction | handshake
//  in      | i_cmd i_index i_addr_* i_prefix_bits i_category | input     | i_in_valid / o_in_ready
//  out     | o_status o_found_category o_matched_length      | output    | o_out_valid / i_out_ready
//  cfg     | i_cfg_index i_cfg_data                          | input     | i_cfg_we, no wait
//
// Writes: the table memory is written at the accept edge, then S_DONE loads the output register.
// Lookups: S_SCAN makes one memory read per entry, n = min(count, table size), then S_FLUSH and
// S_DONE follow; an empty scan (n = 0) goes straight to S_DONE like a write.
// in is ready again once the result loads, so a new item is taken only after the last is through.
// Reset clears control and the counts only; table contents are undefined until written.
// A finished item holds while the output register is full and not taken; in is not ready then.
`default_nettype none

module ip_prefix_category_lookup #(
    parameter int V4_ENTRIES     = ipcl_pkg::V4_ENTRIES_DEF,
    parameter int V6_ENTRIES     = ipcl_pkg::V6_ENTRIES_DEF,
    parameter int CATEGORY_LIMIT = ipcl_pkg::CATEGORY_LIMIT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ipcl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ipcl_pkg::COUNT_W-1:0]        i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [ipcl_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [ipcl_pkg::INDEX_W-1:0]        i_index,
    input  wire logic [ipcl_pkg::HALF_W-1:0]         i_addr_high,
    input  wire logic [ipcl_pkg::HALF_W-1:0]         i_addr_low,
    input  wire logic [ipcl_pkg::PREFIX_W-1:0]       i_prefix_bits,
    input  wire logic [ipcl_pkg::CAT_W-1:0]          i_category,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [ipcl_pkg::STATUS_W-1:0]            o_status,
    output logic [ipcl_pkg::CAT_W-1:0]               o_found_category,
    output logic [ipcl_pkg::PREFIX_W-1:0]            o_matched_length
);

    localparam int AW4    = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
    localparam int AW6    = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
    localparam int EMAX   = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;
    localparam int SCAN_W = $clog2(EMAX + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Control registers
    logic [1:0]                          r_state, n_state;
    logic [ipcl_pkg::COUNT_W-1:0]        r_ipv4_count, r_ipv6_count;
    logic [SCAN_W-1:0]                   r_cnt, n_cnt;
    logic [SCAN_W-1:0]                   r_n, n_n;
    logic                                r_rd_vld;
    logic                                r_out_valid;

    // Item registers
    logic                                r_is_v6, n_is_v6;
    logic                                r_is_lookup, n_is_lookup;
    logic [ipcl_pkg::STATUS_W-1:0]       r_status, n_status;
    logic [ipcl_pkg::KEY_W-1:0]          r_key;
    logic [ipcl_pkg::STATUS_W-1:0]       r_out_status;
    logic [ipcl_pkg::CAT_W-1:0]          r_out_cat;
    logic [ipcl_pkg::PREFIX_W-1:0]       r_out_len;

    logic                                in_acc;
    logic                                is_lookup;
    logic                                cat_ok;
    logic [31:0]                         idx32;
    logic                                wr4_ok, wr6_ok;
    logic                                we4, we6;
    logic [SCAN_W-1:0]                   n4, n6, n_scan;
    logic                                re4, re6;
    logic                                ld_out;
    logic [ipcl_pkg::V4_ENTRY_W-1:0]     rd4;
    logic [ipcl_pkg::V6_ENTRY_W-1:0]     rd6;
    logic [ipcl_pkg::KEY_W-1:0]          m_net;
    logic [ipcl_pkg::PREFIX_W-1:0]       m_len;
    logic [ipcl_pkg::CAT_W-1:0]          m_cat;
    ipcl_pkg::t_scan_ctl                 scan_ctl;
    ipcl_pkg::t_best                     best;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_lookup  = (i_cmd == ipcl_pkg::CMD_LK4) || (i_cmd == ipcl_pkg::CMD_LK6);

    // Write checks
    assign idx32  = 32'(i_index);
    assign cat_ok = (i_category != '0) && (32'(i_category) < 32'(CATEGORY_LIMIT));
    assign wr4_ok = (i_cmd == ipcl_pkg::CMD_WR4) && (i_prefix_bits <= ipcl_pkg::V4_MAX_PREFIX)
                    && cat_ok && (idx32 < 32'(V4_ENTRIES));
    assign wr6_ok = (i_cmd == ipcl_pkg::CMD_WR6) && (i_prefix_bits <= ipcl_pkg::V6_MAX_PREFIX)
                    && cat_ok && (idx32 < 32'(V6_ENTRIES));
    assign we4    = in_acc && wr4_ok;
    assign we6    = in_acc && wr6_ok;

    // Clamp counts to the table sizes
    assign n4 = (32'(r_ipv4_count) > 32'(V4_ENTRIES)) ? SCAN_W'(V4_ENTRIES) : SCAN_W'(r_ipv4_count);
    assign n6 = (32'(r_ipv6_count) > 32'(V6_ENTRIES)) ? SCAN_W'(V6_ENTRIES) : SCAN_W'(r_ipv6_count);
    assign n_scan = (i_cmd == ipcl_pkg::CMD_LK6) ? n6 : n4;

    assign re4 = (r_state == S_SCAN) && !r_is_v6;
    assign re6 = (r_state == S_SCAN) && r_is_v6;

    ipcl_ram #(
        .WIDTH (ipcl_pkg::V4_ENTRY_W),
        .DEPTH (V4_ENTRIES),
        .AW    (AW4)
    ) u_v4_ram (
        .i_clk   (i_clk),
        .i_we    (we4),
        .i_waddr (idx32[AW4-1:0]),
        .i_wdata ({i_addr_low[ipcl_pkg::V4_NET_W-1:0],
                   i_prefix_bits[ipcl_pkg::V4_PREFIX_W-1:0], i_category}),
        .i_re    (re4),
        .i_raddr (r_cnt[AW4-1:0]),
        .o_rdata (rd4)
    );

    ipcl_ram #(
        .WIDTH (ipcl_pkg::V6_ENTRY_W),
        .DEPTH (V6_ENTRIES),
        .AW    (AW6)
    ) u_v6_ram (
        .i_clk   (i_clk),
        .i_we    (we6),
        .i_waddr (idx32[AW6-1:0]),
        .i_wdata ({i_addr_high, i_addr_low, i_prefix_bits, i_category}),
        .i_re    (re6),
        .i_raddr (r_cnt[AW6-1:0]),
        .o_rdata (rd6)
    );

    // Left-align IPv4 entries into the common 128-bit compare
    always_comb begin
        if (r_is_v6) begin
            m_net = rd6[ipcl_pkg::V6_ENTRY_W-1 -: ipcl_pkg::KEY_W];
            m_len = rd6[ipcl_pkg::CAT_W +: ipcl_pkg::PREFIX_W];
            m_cat = rd6[ipcl_pkg::CAT_W-1:0];
        end else begin
            m_net = {rd4[ipcl_pkg::V4_ENTRY_W-1 -: ipcl_pkg::V4_NET_W],
                     (ipcl_pkg::KEY_W - ipcl_pkg::V4_NET_W)'(0)};
            m_len = ipcl_pkg::PREFIX_W'(rd4[ipcl_pkg::CAT_W +: ipcl_pkg::V4_PREFIX_W]);
            m_cat = rd4[ipcl_pkg::CAT_W-1:0];
        end
    end

    assign scan_ctl.start = in_acc;
    assign scan_ctl.eval  = r_rd_vld;

    ipcl_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_key   (r_key),
        .i_net   (m_net),
        .i_len   (m_len),
        .i_cat   (m_cat),
        .o_best  (best)
    );

    assign ld_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_is_v6     = r_is_v6;
        n_is_lookup = r_is_lookup;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_is_v6     = (i_cmd == ipcl_pkg::CMD_LK6);
                    n_is_lookup = is_lookup;
                    n_cnt       = '0;
                    n_n         = n_scan;
                    if (is_lookup) begin
                        n_status = ipcl_pkg::ST_NOMATCH;
                    end else if (wr4_ok || wr6_ok) begin
                        n_status = ipcl_pkg::ST_STORED;
                    end else begin
                        n_status = ipcl_pkg::ST_REJECT;
                    end
                    n_state = (is_lookup && (n_scan != '0)) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (n_cnt == r_n) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last read data is evaluated this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (ld_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_n          <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ipv4_count <= '0;
            r_ipv6_count <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_rd_vld <= (r_state == S_SCAN);
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == ipcl_pkg::REG_IPV4_COUNT)) begin
                r_ipv4_count <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == ipcl_pkg::REG_IPV6_COUNT)) begin
                r_ipv6_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_v6     <= n_is_v6;
        r_is_lookup <= n_is_lookup;
        r_status    <= n_status;
        if (in_acc) begin
            r_key <= (i_cmd == ipcl_pkg::CMD_LK6) ? {i_addr_high, i_addr_low}
                   : {i_addr_low[ipcl_pkg::V4_NET_W-1:0],
                      (ipcl_pkg::KEY_W - ipcl_pkg::V4_NET_W)'(0)};
        end
        if (ld_out) begin
            if (r_is_lookup && best.found) begin
                r_out_status <= ipcl_pkg::ST_MATCH;
                r_out_cat    <= best.cat;
                r_out_len    <= best.len;
            end else begin
                r_out_status <= r_status;
                r_out_cat    <= '0;
                r_out_len    <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_category = r_out_cat;
    assign o_matched_length = r_out_len;

`ifndef SYNTH
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt < r_n))
        else $error("scan address past clamped count");

    a_lookup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_lookup) |=> ((r_state == S_SCAN) || (r_state == S_DONE)))
        else $error("lookup did not start a scan");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == S_SCAN) || (r_state == S_FLUSH)))
        else $error("table read data arrived outside a scan");

    a_match_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ipcl_pkg::ST_MATCH)) |-> (o_matched_length <= 8'd128))
        else $error("matched length above 128");
`endif

endmodule

`default_nettype wire

### tb/sv/ip_prefix_category_lookup_tb.sv
// Testbench for the IP prefix category lookup: table writes and scans checked against a predictor.
module ip_prefix_category_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipcl_pkg::*;

    localparam int V4_SLOTS    = V4_ENTRIES_DEF;
    localparam int V6_SLOTS    = V6_ENTRIES_DEF;
    localparam int CAT_LIMIT   = CATEGORY_LIMIT_DEF;
    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [INDEX_W-1:0]  slot;
        logic [HALF_W-1:0]   addr_high;
        logic [HALF_W-1:0]   addr_low;
        logic [PREFIX_W-1:0] prefix_bits;
        logic [CAT_W-1:0]    category;
    } prefix_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CAT_W-1:0]    category;
        logic [PREFIX_W-1:0] plen;
    } prefix_reply_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COUNT_W-1:0]   i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    prefix_req_t          drive_req   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [CAT_W-1:0]     o_found_category;
    logic [PREFIX_W-1:0]  o_matched_length;

    // Mirror of the tables and counts
    logic [31:0] v4_net  [V4_SLOTS];
    logic [7:0]  v4_plen [V4_SLOTS];
    logic [7:0]  v4_cat  [V4_SLOTS];
    logic [63:0] v6_hi   [V6_SLOTS];
    logic [63:0] v6_lo   [V6_SLOTS];
    logic [7:0]  v6_plen [V6_SLOTS];
    logic [7:0]  v6_cat  [V6_SLOTS];
    int          v4_count = 0;
    int          v6_count = 0;

    logic [7:0]  v4_tops [4] = '{8'h0A, 8'hAC, 8'hC0, 8'hE0};
    logic [15:0] v6_tops [4] = '{16'h2001, 16'h2A00, 16'hFD00, 16'hFE80};

    prefix_req_t   cmds_waiting [$];
    prefix_reply_t replies_due  [$];

    int  sent_cnt     = 0;
    int  accepted_cnt = 0;
    int  n_items      = 0;
    int  bad_replies  = 0;
    int  cycle_count  = 0;
    int  send_gap     = 0;
    int  recv_stall   = 0;
    bit  idle_en      = 1'b1;

    ip_prefix_category_lookup dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (drive_req.cmd),
        .i_index          (drive_req.slot),
        .i_addr_high      (drive_req.addr_high),
        .i_addr_low       (drive_req.addr_low),
        .i_prefix_bits    (drive_req.prefix_bits),
        .i_category       (drive_req.category),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_category (o_found_category),
        .o_matched_length (o_matched_length)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] v4_mask(input int len);
        return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
    endfunction

    function automatic logic [127:0] v6_mask(input int len);
        return (len == 0) ? 128'h0 : ({128{1'b1}} << (128 - len));
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Apply one item to the table mirror and return the reply it must produce
    function automatic prefix_reply_t table_reply(input prefix_req_t r);
        prefix_reply_t res;
        int            lim;
        logic          cat_ok;
        logic [127:0]  key;
        res = '{status: ST_NOMATCH, category: '0, plen: '0};
        cat_ok = (r.category != 0) && (r.category < CAT_LIMIT);
        key = {r.addr_high, r.addr_low};
        case (r.cmd)
            CMD_WR4: begin
                if (r.prefix_bits <= V4_MAX_PREFIX && cat_ok) begin
                    v4_net[r.slot]  = r.addr_low[31:0];
                    v4_plen[r.slot] = r.prefix_bits;
                    v4_cat[r.slot]  = r.category;
                    res.status = ST_STORED;
                end else begin
                    res.status = ST_REJECT;
                end
            end
            CMD_WR6: begin
                if (r.prefix_bits <= V6_MAX_PREFIX && cat_ok) begin
                    v6_hi[r.slot]   = r.addr_high;
                    v6_lo[r.slot]   = r.addr_low;
                    v6_plen[r.slot] = r.prefix_bits;
                    v6_cat[r.slot]  = r.category;
                    res.status = ST_STORED;
                end else begin
                    res.status = ST_REJECT;
                end
            end
            CMD_LK4: begin
                lim = (v4_count > V4_SLOTS) ? V4_SLOTS : v4_count;
                for (int i = 0; i < lim; i++) begin
                    // strictly longer only, so the lowest slot keeps a tie
                    if (((r.addr_low[31:0] ^ v4_net[i]) & v4_mask(v4_plen[i])) == 0 &&
                        (res.status == ST_NOMATCH || v4_plen[i] > res.plen)) begin
                        res.status   = ST_MATCH;
                        res.plen     = v4_plen[i];
                        res.category = v4_cat[i];
                    end
                end
            end
            default: begin
                lim = (v6_count > V6_SLOTS) ? V6_SLOTS : v6_count;
                for (int i = 0; i < lim; i++) begin
                    if (((key ^ {v6_hi[i], v6_lo[i]}) & v6_mask(v6_plen[i])) == 0 &&
                        (res.status == ST_NOMATCH || v6_plen[i] > res.plen)) begin
                        res.status   = ST_MATCH;
                        res.plen     = v6_plen[i];
                        res.category = v6_cat[i];
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic prefix_req_t make_noise();
        prefix_req_t r;
        r.cmd         = CMD_W'($urandom_range(0, 3));
        r.slot        = INDEX_W'($urandom);
        r.addr_high   = rand64();
        r.addr_low    = rand64();
        r.prefix_bits = PREFIX_W'($urandom);
        r.category    = CAT_W'($urandom);
        return r;
    endfunction

    function automatic prefix_req_t make_req(input logic [CMD_W-1:0] cmd, input int slot,
                                             input logic [63:0] ah, input logic [63:0] al,
                                             input int plen, input int cat);
        prefix_req_t r;
        r.cmd         = cmd;
        r.slot        = INDEX_W'(slot);
        r.addr_high   = ah;
        r.addr_low    = al;
        r.prefix_bits = PREFIX_W'(plen);
        r.category    = CAT_W'(cat);
        return r;
    endfunction

    function automatic prefix_req_t make_v4_write(input int slot);
        prefix_req_t r;
        int          src;
        int          plen;
        logic [31:0] m;
        logic [31:0] net;
        r = make_noise();
        r.cmd      = CMD_WR4;
        r.slot     = INDEX_W'(slot);
        r.category = CAT_W'($urandom_range(1, CAT_LIMIT - 1));
        if ($urandom_range(0, 2) == 0) begin
            // nest under an existing entry so longer prefixes compete
            src  = $urandom_range(0, V4_SLOTS - 1);
            m    = v4_mask(v4_plen[src]);
            net  = (v4_net[src] & m) | ($urandom & ~m);
            plen = $urandom_range(v4_plen[src], 32);
        end else begin
            net  = {v4_tops[$urandom_range(0, 3)], 24'($urandom)};
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 28);
        end
        r.addr_low[31:0] = net;
        r.prefix_bits    = PREFIX_W'(plen);
        return r;
    endfunction

    function automatic prefix_req_t make_v6_write(input int slot);
        prefix_req_t  r;
        int           src;
        int           plen;
        logic [127:0] m;
        logic [127:0] key;
        r = make_noise();
        r.cmd      = CMD_WR6;
        r.slot     = INDEX_W'(slot);
        r.category = CAT_W'($urandom_range(1, CAT_LIMIT - 1));
        key = {r.addr_high, r.addr_low};
        if ($urandom_range(0, 2) == 0) begin
            src  = $urandom_range(0, V6_SLOTS - 1);
            m    = v6_mask(v6_plen[src]);
            key  = ({v6_hi[src], v6_lo[src]} & m) | (key & ~m);
            plen = $urandom_range(v6_plen[src], 128);
        end else begin
            key[127:112] = v6_tops[$urandom_range(0, 3)];
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 128) : $urandom_range(16, 64);
        end
        r.addr_high   = key[127:64];
        r.addr_low    = key[63:0];
        r.prefix_bits = PREFIX_W'(plen);
        return r;
    endfunction

    function automatic prefix_req_t make_lookup(input bit is_v6);
        prefix_req_t  r;
        int           lim;
        int           pick;
        int           s;
        logic [31:0]  m4;
        logic [127:0] m6;
        logic [127:0] key;
        r = make_noise();
        r.cmd = is_v6 ? CMD_LK6 : CMD_LK4;
        lim = is_v6 ? ((v6_count > V6_SLOTS) ? V6_SLOTS : v6_count)
                    : ((v4_count > V4_SLOTS) ? V4_SLOTS : v4_count);
        pick = $urandom_range(0, 9);
        if (lim > 0 && pick < 6) begin
            // aim inside a live entry's range
            s = $urandom_range(0, lim - 1);
            if (is_v6) begin
                m6  = v6_mask(v6_plen[s]);
                key = ({v6_hi[s], v6_lo[s]} & m6) | ({r.addr_high, r.addr_low} & ~m6);
                r.addr_high = key[127:64];
                r.addr_low  = key[63:0];
            end else begin
                m4 = v4_mask(v4_plen[s]);
                r.addr_low[31:0] = (v4_net[s] & m4) | (r.addr_low[31:0] & ~m4);
            end
        end else if (pick < 8) begin
            r.addr_high[63:48] = v6_tops[$urandom_range(0, 3)];
            r.addr_low[31:24]  = v4_tops[$urandom_range(0, 3)];
        end
        return r;
    endfunction

    task automatic queue_cmd(input prefix_req_t r);
        cmds_waiting.push_back(r);
        n_items++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmds_waiting.size() != 0 || sent_cnt != accepted_cnt || replies_due.size() != 0);
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] reg_sel, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data  <= COUNT_W'(value);
        if (reg_sel == REG_IPV4_COUNT) begin
            v4_count = value;
        end else begin
            v6_count = value;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender and receiver, both driven at the falling edge
    always @(negedge i_clk) begin : driver
        logic        nxt_valid;
        logic        nxt_ready;
        prefix_req_t nxt_req;
        nxt_valid = i_in_valid;
        nxt_ready = i_out_ready;
        nxt_req   = drive_req;
        if (i_rst_n) begin
            if (i_in_valid && accepted_cnt == sent_cnt) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmds_waiting.size() > 0) begin
                    if (idle_en && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 13);
                    end else begin
                        nxt_req   = cmds_waiting.pop_front();
                        nxt_valid = 1'b1;
                        sent_cnt++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                nxt_ready = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 13);
                nxt_ready  = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_in_valid  <= nxt_valid;
        i_out_ready <= nxt_ready;
        drive_req   <= nxt_req;
    end

    always @(posedge i_clk) begin : monitor
        prefix_reply_t want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                replies_due.push_back(table_reply(drive_req));
                accepted_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    bad_replies++;
                    if (bad_replies <= MAX_REPORTS) begin
                        $display("t=%0t reply with no item waiting: status %0d cat %0d len %0d",
                                 $time, o_status, o_found_category, o_matched_length);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (o_status != want.status || o_found_category != want.category ||
                        o_matched_length != want.plen) begin
                        bad_replies++;
                        if (bad_replies <= MAX_REPORTS) begin
                            $display("t=%0t reply wrong: want status %0d cat %0d len %0d, got status %0d cat %0d len %0d",
                                     $time, want.status, want.category, want.plen,
                                     o_status, o_found_category, o_matched_length);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int phase;
        int c4;
        int c6;
        int pick;
        int n_phase;
        foreach (v4_net[i]) begin
            v4_net[i]  = '0;
            v4_plen[i] = '0;
            v4_cat[i]  = '0;
        end
        foreach (v6_hi[i]) begin
            v6_hi[i]   = '0;
            v6_lo[i]   = '0;
            v6_plen[i] = '0;
            v6_cat[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty scans, field extremes, every rejection reason
        queue_cmd(make_req(CMD_LK4, 0, '0, '0, 0, 0));
        queue_cmd(make_req(CMD_LK6, 255, '1, '1, 255, 255));
        queue_cmd(make_req(CMD_WR4, 0, '1, '1, 32, CAT_LIMIT - 1));
        queue_cmd(make_req(CMD_WR4, 1, '0, 64'h0123_4567_89AB_CDEF, 0, 1));
        queue_cmd(make_req(CMD_WR4, 2, '0, '0, 0, 5));
        queue_cmd(make_req(CMD_WR4, 255, '0, 64'hC0A8_0000, 16, 9));
        queue_cmd(make_req(CMD_WR4, 3, '0, '0, 33, 3));
        queue_cmd(make_req(CMD_WR4, 3, '0, '0, 255, 3));
        queue_cmd(make_req(CMD_WR4, 3, '0, '0, 8, 0));
        queue_cmd(make_req(CMD_WR4, 3, '0, '0, 8, CAT_LIMIT));
        queue_cmd(make_req(CMD_WR4, 3, '0, '0, 8, 255));
        queue_cmd(make_req(CMD_WR6, 0, '1, '1, 128, CAT_LIMIT - 1));
        queue_cmd(make_req(CMD_WR6, 1, rand64(), rand64(), 0, 1));
        queue_cmd(make_req(CMD_WR6, 2, '0, '0, 0, 5));
        queue_cmd(make_req(CMD_WR6, 255, 64'h2001_0DB8_0000_0000, '0, 32, 64));
        queue_cmd(make_req(CMD_WR6, 3, '0, '0, 129, 2));
        queue_cmd(make_req(CMD_WR6, 3, '0, '0, 64, 0));
        queue_cmd(make_req(CMD_WR6, 3, '0, '0, 64, CAT_LIMIT));
        wait_drained();
        write_count(REG_IPV4_COUNT, 3);
        write_count(REG_IPV6_COUNT, 3);

        // Full-length hits, then zero-length ties where the lower slot wins
        queue_cmd(make_req(CMD_LK4, 7, '0, 64'h0000_0000_FFFF_FFFF, 0, 0));
        queue_cmd(make_req(CMD_LK4, 7, '0, 64'hFFFF_FFFF_0000_0000, 0, 0));
        queue_cmd(make_req(CMD_LK6, 7, '1, '1, 0, 0));
        queue_cmd(make_req(CMD_LK6, 7, '1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0));
        queue_cmd(make_req(CMD_LK6, 7, '0, '0, 0, 0));

        // Fill both tables so any count becomes legal
        for (int j = 3; j < V4_SLOTS; j++) begin
            queue_cmd(make_v4_write(j));
            queue_cmd(make_v6_write(j));
            pick = $urandom_range(0, 15);
            if (pick < 4) begin
                queue_cmd(make_lookup(pick[0]));
            end else if (pick == 4) begin
                queue_cmd(make_noise());
            end
        end

        phase = 0;
        while (n_items < ITEM_TARGET) begin
            wait_drained();
            case (phase)
                0: begin c4 = V4_SLOTS; c6 = V6_SLOTS; end
                1: begin c4 = 511; c6 = 0; end
                2: begin c4 = 0; c6 = V6_SLOTS + 1; end
                default: begin
                    c4 = ($urandom_range(0, 7) == 0) ? $urandom_range(V4_SLOTS + 1, 511)
                                                      : $urandom_range(0, V4_SLOTS);
                    c6 = ($urandom_range(0, 7) == 0) ? $urandom_range(V6_SLOTS + 1, 511)
                                                      : $urandom_range(0, V6_SLOTS);
                end
            endcase
            write_count(REG_IPV4_COUNT, c4);
            write_count(REG_IPV6_COUNT, c6);
            // no idling near the end; otherwise mostly on
            idle_en = (n_items + 60 >= ITEM_TARGET) ? 1'b0 : ($urandom_range(0, 3) != 0);
            n_phase = $urandom_range(20, 60);
            repeat (n_phase) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    queue_cmd(make_lookup(pick[0]));
                end else if (pick < 18) begin
                    if (pick[0]) begin
                        queue_cmd(make_v6_write($urandom_range(0, V6_SLOTS - 1)));
                    end else begin
                        queue_cmd(make_v4_write($urandom_range(0, V4_SLOTS - 1)));
                    end
                end else begin
                    queue_cmd(make_noise());
                end
            end
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (bad_replies == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/ipcl_pkg.sv
rtl/ipcl_ram.sv
rtl/ipcl_match.sv
rtl/ip_prefix_category_lookup.sv
tb/sv/ip_prefix_category_lookup_tb.sv
